// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Same, on the house clock and reset names.
`define ASSERT_STD(label, prop) `ASSERT_CLK(label, i_clk, i_rst_n, prop)

`endif

// ===== hw/rtl/bqc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_pkg
// Types, codes and arithmetic helpers of the billboard quad corner pipeline.
// ----------------------------------------------------------------------------
package bqc_pkg;

    // Number of pipeline stages in each of the iterative units.
    localparam int SqrtStages = 8;
    localparam int SqrtStepsPerStage = 4;
    localparam int DivStages = 8;
    localparam int DivStepsPerStage = 4;

    localparam logic signed [33:0] SatMax = 34'sd2147483647;
    localparam logic signed [33:0] SatMin = -34'sd2147483648;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_CAMERA_X    = 3'd0,
        REG_CAMERA_Y    = 3'd1,
        REG_CAMERA_Z    = 3'd2,
        REG_QUAD_WIDTH  = 3'd3,
        REG_QUAD_HEIGHT = 3'd4
    } t_reg_idx;

    // Corner order of the results.
    typedef enum logic [1:0] {
        CORNER_UR = 2'd0,
        CORNER_UL = 2'd1,
        CORNER_BR = 2'd2,
        CORNER_BL = 2'd3
    } t_corner;

    // Per-item data that rides along the whole pipeline.
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic               dx_pos;
        logic               dx_neg;
        logic               dz_pos;
        logic               dz_neg;
        logic               degen;
    } t_side;

    // Normalized magnitudes of the view offset.
    typedef struct packed {
        logic [30:0] ax;
        logic [30:0] az;
    } t_mag;

    // Square root iteration state.
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } t_sqrt;

    // Restoring divider lane state.
    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
    } t_div;

    // Left shift that brings the top set bit of m to bit 30.
    function automatic logic [4:0] norm_shift(input logic [30:0] m);
        logic [4:0] sh;
        sh = '0;
        for (int i = 0; i < 31; i++) begin
            if (m[i]) begin
                sh = 5'(30 - i);
            end
        end
        return sh;
    endfunction

    // One bit of the bitwise integer square root.
    function automatic t_sqrt sqrt_step(input t_sqrt s, input int unsigned step);
        logic [63:0] b;
        logic [63:0] trial;
        t_sqrt       r;
        b     = 64'd1 << (62 - 2 * step);
        trial = s.root + b;
        if (s.rem >= trial) begin
            r.rem  = s.rem - trial;
            r.root = (s.root >> 1) + b;
        end else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

    // One quotient bit of the restoring divider.
    function automatic t_div div_step(input t_div s, input logic [32:0] d);
        logic [33:0] r2;
        t_div        r;
        r2 = {s.rem, s.low[31]};
        if (r2 >= {1'b0, d}) begin
            r.rem = 33'(r2 - {1'b0, d});
            r.quo = {s.quo[30:0], 1'b1};
        end else begin
            r.rem = r2[32:0];
            r.quo = {s.quo[30:0], 1'b0};
        end
        r.low = {s.low[30:0], 1'b0};
        return r;
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > SatMax) begin
            r = 32'sh7fffffff;
        end else if (v < SatMin) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bqc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_if
// Valid/ready channels of the billboard quad corner block.
// ----------------------------------------------------------------------------

// Particle centre channel.
interface bqc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    modport source (output valid, centre_x, centre_y, centre_z, input ready);
    modport sink (input valid, centre_x, centre_y, centre_z, output ready);
endinterface

// Corner result channel.
interface bqc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         corner_index;
    logic signed [31:0] corner_x;
    logic signed [31:0] corner_y;
    logic signed [31:0] corner_z;
    logic               degenerate;
    logic               final_corner;
    modport source (output valid, corner_index, corner_x, corner_y, corner_z,
                    degenerate, final_corner, input ready);
    modport sink (input valid, corner_index, corner_x, corner_y, corner_z,
                  degenerate, final_corner, output ready);
endinterface

// Register write channel.
interface bqc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/billboard_quad_corners.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// billboard_quad_corners
// Expands a particle centre into the four corners of a camera-facing quad.
// ----------------------------------------------------------------------------
// Usage:
//   i_in takes one particle centre (signed Q16.16) per transaction. o_out
//   gives four transactions per particle, in the order upper right, upper
//   left, bottom right, bottom left; final_corner marks the last one. i_cfg
//   writes camera position and quad size, is always ready and drops unknown
//   indexes. The user must write it only while no particle is in flight (unchecked).
// Path: 5 front stages, 8 square root stages, 10 offset stages, the corner
//   hold stage and the output register; the first front stage loads at the
//   accepting edge.
// Throughput: set by the four corner transactions per particle on the output
//   port; the pipeline itself takes one per cycle while it is not held.
// Stall: i_in.ready drops and the whole pipeline holds while the corner hold stage
//   is full and not loading its last corner; no transaction is lost or repeated.
// Reset: synchronous, active low; clears all valid bits and sets camera to
//   the origin and quad width and height to 1.0.
// ----------------------------------------------------------------------------
module billboard_quad_corners (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bqc_in_if.sink     i_in,
    bqc_cfg_if.sink    i_cfg,
    bqc_out_if.source  o_out
);
    import bqc_pkg::*;

    // Configuration registers
    logic signed [31:0] r_cam_x;
    logic signed [31:0] r_cam_y;
    logic signed [31:0] r_cam_z;
    logic [30:0]        r_width;
    logic [30:0]        r_height;

    logic        w_en;
    logic        w_f_valid;
    t_side       w_f_side;
    t_mag        w_f_mag;
    logic [62:0] w_f_sum;
    logic        w_s_valid;
    t_side       w_s_side;
    t_mag        w_s_mag;
    logic [31:0] w_s_len;
    logic        w_o_valid;
    t_side       w_o_side;
    logic [30:0] w_o_ox;
    logic [30:0] w_o_oz;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_en;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x  <= '0;
            r_cam_y  <= '0;
            r_cam_z  <= '0;
            r_width  <= 31'd65536;
            r_height <= 31'd65536;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_CAMERA_X:    r_cam_x  <= i_cfg.data;
                REG_CAMERA_Y:    r_cam_y  <= i_cfg.data;
                REG_CAMERA_Z:    r_cam_z  <= i_cfg.data;
                REG_QUAD_WIDTH:  r_width  <= i_cfg.data[30:0];
                REG_QUAD_HEIGHT: r_height <= i_cfg.data[30:0];
                default: ;
            endcase
        end
    end

    bqc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_cx    (i_in.centre_x),
        .i_cy    (i_in.centre_y),
        .i_cz    (i_in.centre_z),
        .i_cam_x (r_cam_x),
        .i_cam_z (r_cam_z),
        .o_valid (w_f_valid),
        .o_side  (w_f_side),
        .o_mag   (w_f_mag),
        .o_sum   (w_f_sum)
    );

    bqc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_side  (w_f_side),
        .i_mag   (w_f_mag),
        .i_sum   (w_f_sum),
        .o_valid (w_s_valid),
        .o_side  (w_s_side),
        .o_mag   (w_s_mag),
        .o_len   (w_s_len)
    );

    bqc_offset u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_side  (w_s_side),
        .i_mag   (w_s_mag),
        .i_len   (w_s_len),
        .i_width (r_width),
        .o_valid (w_o_valid),
        .o_side  (w_o_side),
        .o_ox    (w_o_ox),
        .o_oz    (w_o_oz)
    );

    // Camera y does not enter the right vector; held for the full register set
    logic w_cam_y_unused;
    assign w_cam_y_unused = ^r_cam_y;

    bqc_corner u_corner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_o_valid),
        .i_side   (w_o_side),
        .i_ox     (w_o_ox),
        .i_oz     (w_o_oz),
        .i_height (r_height),
        .o_en     (w_en),
        .o_out    (o_out)
    );

endmodule

// ===== hw/rtl/bqc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_front
// View offset, magnitude normalization and sum of squares, five stages.
// ----------------------------------------------------------------------------
module bqc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_cx,
    input  logic signed [31:0] i_cy,
    input  logic signed [31:0] i_cz,
    input  logic signed [31:0] i_cam_x,
    input  logic signed [31:0] i_cam_z,
    output logic               o_valid,
    output bqc_pkg::t_side     o_side,
    output bqc_pkg::t_mag      o_mag,
    output logic [62:0]        o_sum
);
    import bqc_pkg::*;

    logic [4:0] r_valid;

    t_side              r1_side;
    logic signed [32:0] r1_dx;
    logic signed [32:0] r1_dz;

    t_side       r2_side;
    logic [32:0] r2_ax;
    logic [32:0] r2_az;
    logic        r2_right;
    logic [4:0]  r2_sh;

    t_side r3_side;
    t_mag  r3_mag;

    t_side       r4_side;
    t_mag        r4_mag;
    logic [61:0] r4_sqx;
    logic [61:0] r4_sqz;

    t_side       r5_side;
    t_mag        r5_mag;
    logic [62:0] r5_sum;

    t_side       n2_side;
    logic [32:0] n2_ax;
    logic [32:0] n2_az;
    logic [32:0] n2_m;
    t_mag        n3_mag;

    // Stage 2: magnitudes, signs and normalization shift
    always_comb begin
        n2_ax = r1_dx[32] ? 33'(-r1_dx) : 33'(r1_dx);
        n2_az = r1_dz[32] ? 33'(-r1_dz) : 33'(r1_dz);
        n2_m  = n2_ax | n2_az;
        n2_side        = r1_side;
        n2_side.dx_pos = !r1_dx[32] && (r1_dx != '0);
        n2_side.dx_neg = r1_dx[32];
        n2_side.dz_pos = !r1_dz[32] && (r1_dz != '0);
        n2_side.dz_neg = r1_dz[32];
        n2_side.degen  = (n2_m == '0);
    end

    // Stage 3: bring the larger magnitude into [2^30, 2^31)
    always_comb begin
        if (r2_right) begin
            n3_mag.ax = r2_ax[31:1];
            n3_mag.az = r2_az[31:1];
        end else begin
            n3_mag.ax = r2_ax[30:0] << r2_sh;
            n3_mag.az = r2_az[30:0] << r2_sh;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side        <= '{cx: i_cx, cy: i_cy, cz: i_cz, default: '0};
            r1_dx          <= 33'(i_cx) - 33'(i_cam_x);
            r1_dz          <= 33'(i_cz) - 33'(i_cam_z);

            r2_side  <= n2_side;
            r2_ax    <= n2_ax;
            r2_az    <= n2_az;
            r2_right <= n2_m[32] | n2_m[31];
            r2_sh    <= norm_shift(n2_m[30:0]);

            r3_side <= r2_side;
            r3_mag  <= n3_mag;

            r4_side <= r3_side;
            r4_mag  <= r3_mag;
            r4_sqx  <= r3_mag.ax * r3_mag.ax;
            r4_sqz  <= r3_mag.az * r3_mag.az;

            r5_side <= r4_side;
            r5_mag  <= r4_mag;
            r5_sum  <= 63'(r4_sqx) + 63'(r4_sqz);
        end
    end

    assign o_valid = r_valid[4];
    assign o_side  = r5_side;
    assign o_mag   = r5_mag;
    assign o_sum   = r5_sum;

endmodule

// ===== hw/rtl/bqc_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_sqrt
// Pipelined bitwise square root, four result bits per stage.
// ----------------------------------------------------------------------------
module bqc_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  bqc_pkg::t_side i_side,
    input  bqc_pkg::t_mag  i_mag,
    input  logic [62:0]    i_sum,
    output logic           o_valid,
    output bqc_pkg::t_side o_side,
    output bqc_pkg::t_mag  o_mag,
    output logic [31:0]    o_len
);
    import bqc_pkg::*;

    logic  r_valid [SqrtStages];
    t_side r_side  [SqrtStages];
    t_mag  r_mag   [SqrtStages];
    t_sqrt r_st    [SqrtStages];

    for (genvar g = 0; g < SqrtStages; g++) begin : g_stage
        logic  w_valid;
        t_side w_side;
        t_mag  w_mag;
        t_sqrt w_in;
        t_sqrt w_out;

        // Stage input: pipeline entry or the previous stage
        if (g == 0) begin : g_first
            assign w_valid     = i_valid;
            assign w_side      = i_side;
            assign w_mag       = i_mag;
            assign w_in.rem    = 64'(i_sum);
            assign w_in.root   = '0;
        end else begin : g_next
            assign w_valid = r_valid[g-1];
            assign w_side  = r_side[g-1];
            assign w_mag   = r_mag[g-1];
            assign w_in    = r_st[g-1];
        end

        // Four root bits
        always_comb begin
            w_out = w_in;
            for (int k = 0; k < SqrtStepsPerStage; k++) begin
                w_out = sqrt_step(w_out, g * SqrtStepsPerStage + k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= w_side;
                r_mag[g]  <= w_mag;
                r_st[g]   <= w_out;
            end
        end
    end

    assign o_valid = r_valid[SqrtStages-1];
    assign o_side  = r_side[SqrtStages-1];
    assign o_mag   = r_mag[SqrtStages-1];
    assign o_len   = r_st[SqrtStages-1].root[31:0];

endmodule

// ===== hw/rtl/bqc_offset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_offset
// Half-width offsets: width products, rounding add and a pipelined
// two-lane restoring divider by twice the length.
// ----------------------------------------------------------------------------
module bqc_offset (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  bqc_pkg::t_side i_side,
    input  bqc_pkg::t_mag  i_mag,
    input  logic [31:0]    i_len,
    input  logic [30:0]    i_width,
    output logic           o_valid,
    output bqc_pkg::t_side o_side,
    output logic [30:0]    o_ox,
    output logic [30:0]    o_oz
);
    import bqc_pkg::*;

    // Product stage
    logic        r_m_valid;
    t_side       r_m_side;
    logic [31:0] r_m_len;
    logic [61:0] r_m_px;
    logic [61:0] r_m_pz;

    // Rounding add stage
    logic        r_a_valid;
    t_side       r_a_side;
    logic [32:0] r_a_div;
    logic [62:0] r_a_nx;
    logic [62:0] r_a_nz;

    // Divider stages
    logic        r_valid [DivStages];
    t_side       r_side  [DivStages];
    logic [32:0] r_div   [DivStages];
    t_div        r_lx    [DivStages];
    t_div        r_lz    [DivStages];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= i_valid;
            r_a_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_side <= i_side;
            r_m_len  <= i_len;
            r_m_px   <= i_width * i_mag.az;
            r_m_pz   <= i_width * i_mag.ax;

            r_a_side <= r_m_side;
            r_a_div  <= {r_m_len, 1'b0};
            r_a_nx   <= 63'(r_m_px) + 63'(r_m_len);
            r_a_nz   <= 63'(r_m_pz) + 63'(r_m_len);
        end
    end

    for (genvar g = 0; g < DivStages; g++) begin : g_stage
        logic        w_valid;
        t_side       w_side;
        logic [32:0] w_div;
        t_div        w_inx;
        t_div        w_inz;
        t_div        w_outx;
        t_div        w_outz;

        // Stage input: numerator load or the previous stage
        if (g == 0) begin : g_first
            assign w_valid   = r_a_valid;
            assign w_side    = r_a_side;
            assign w_div     = r_a_div;
            assign w_inx.rem = {2'b00, r_a_nx[62:32]};
            assign w_inx.low = r_a_nx[31:0];
            assign w_inx.quo = '0;
            assign w_inz.rem = {2'b00, r_a_nz[62:32]};
            assign w_inz.low = r_a_nz[31:0];
            assign w_inz.quo = '0;
        end else begin : g_next
            assign w_valid = r_valid[g-1];
            assign w_side  = r_side[g-1];
            assign w_div   = r_div[g-1];
            assign w_inx   = r_lx[g-1];
            assign w_inz   = r_lz[g-1];
        end

        // Four quotient bits on each lane
        always_comb begin
            w_outx = w_inx;
            w_outz = w_inz;
            for (int k = 0; k < DivStepsPerStage; k++) begin
                w_outx = div_step(w_outx, w_div);
                w_outz = div_step(w_outz, w_div);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= w_side;
                r_div[g]  <= w_div;
                r_lx[g]   <= w_outx;
                r_lz[g]   <= w_outz;
            end
        end
    end

    // Quotient stays below 2^31 since the length is at least either magnitude
    assign o_valid = r_valid[DivStages-1];
    assign o_side  = r_side[DivStages-1];
    assign o_ox    = r_lx[DivStages-1].quo[30:0];
    assign o_oz    = r_lz[DivStages-1].quo[30:0];

endmodule

// ===== hw/rtl/bqc_corner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_corner
// Holds one finished particle and sends its four corners through a
// registered output, with saturation. Drives the pipeline advance.
// ----------------------------------------------------------------------------
module bqc_corner (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  bqc_pkg::t_side i_side,
    input  logic [30:0]    i_ox,
    input  logic [30:0]    i_oz,
    input  logic [30:0]    i_height,
    output logic           o_en,
    bqc_out_if.source      o_out
);
    import bqc_pkg::*;

    // Held particle
    logic               r_hold_valid;
    t_corner            r_cnt;
    t_side              r_side;
    logic signed [31:0] r_rx;
    logic signed [31:0] r_rz;
    logic [30:0]        r_hy;

    // Output register
    logic               r_o_valid;
    t_corner            r_o_index;
    logic signed [31:0] r_o_x;
    logic signed [31:0] r_o_y;
    logic signed [31:0] r_o_z;
    logic               r_o_degen;

    logic               w_load;
    logic signed [31:0] n_rx;
    logic signed [31:0] n_rz;
    logic signed [33:0] w_sx;
    logic signed [33:0] w_sy;
    logic signed [33:0] w_sz;
    logic signed [33:0] w_hy;

    // Output register takes a corner when empty or being drained
    assign w_load = r_hold_valid && (!r_o_valid || o_out.ready);
    assign o_en   = !r_hold_valid || (w_load && (r_cnt == CORNER_BL));

    // Signed right offsets
    always_comb begin
        n_rx = '0;
        n_rz = '0;
        if (i_side.dz_pos) begin
            n_rx = $signed({1'b0, i_ox});
        end else if (i_side.dz_neg) begin
            n_rx = -$signed({1'b0, i_ox});
        end
        if (i_side.dx_pos) begin
            n_rz = -$signed({1'b0, i_oz});
        end else if (i_side.dx_neg) begin
            n_rz = $signed({1'b0, i_oz});
        end
    end

    // Corner sums: bit 0 flips right, bit 1 flips up
    always_comb begin
        w_hy = $signed({3'b000, r_hy});
        if (r_cnt[0]) begin
            w_sx = 34'(r_side.cx) - 34'(r_rx);
            w_sz = 34'(r_side.cz) - 34'(r_rz);
        end else begin
            w_sx = 34'(r_side.cx) + 34'(r_rx);
            w_sz = 34'(r_side.cz) + 34'(r_rz);
        end
        if (r_cnt[1]) begin
            w_sy = 34'(r_side.cy) - w_hy;
        end else begin
            w_sy = 34'(r_side.cy) + w_hy;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_cnt        <= CORNER_UR;
            r_o_valid    <= 1'b0;
        end else begin
            if (o_en) begin
                r_hold_valid <= i_valid;
                r_cnt        <= CORNER_UR;
            end else if (w_load) begin
                r_cnt <= t_corner'(r_cnt + 2'd1);
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_side <= i_side;
            r_rx   <= n_rx;
            r_rz   <= n_rz;
            r_hy   <= 31'(({1'b0, i_height} + 32'd1) >> 1);
        end
        if (w_load) begin
            r_o_index <= r_cnt;
            r_o_x     <= sat32(w_sx);
            r_o_y     <= sat32(w_sy);
            r_o_z     <= sat32(w_sz);
            r_o_degen <= r_side.degen;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.corner_index = r_o_index;
    assign o_out.corner_x     = r_o_x;
    assign o_out.corner_y     = r_o_y;
    assign o_out.corner_z     = r_o_z;
    assign o_out.degenerate   = r_o_degen;
    assign o_out.final_corner = (r_o_index == CORNER_BL);

endmodule

// ===== hw/rtl/bqc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_checker
// Port-level checks of the corner output sequence, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bqc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_index,
    input logic [31:0] i_x,
    input logic        i_degen,
    input logic        i_final
);
    import bqc_pkg::*;

    // Only the bottom left corner closes a quad
    `ASSERT_STD(a_final_last, i_valid |-> (i_final == (i_index == CORNER_BL)))

    // Corners of one quad follow each other without a gap
    `ASSERT_STD(a_index_seq, (i_valid && i_ready && !i_final) |=> (i_valid && (i_index == $past(i_index) + 2'd1)))

    // Degenerate flag is the same on all corners of a quad
    `ASSERT_STD(a_degen_quad, (i_valid && i_ready && !i_final) |=> (i_degen == $past(i_degen)))

    // Stalled corner holds
    `ASSERT_STD(a_stall_hold, (i_valid && !i_ready) |=> (i_valid && $stable(i_x) && $stable(i_index)))

endmodule

bind billboard_quad_corners bqc_checker u_bqc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_index (o_out.corner_index),
    .i_x     (o_out.corner_x),
    .i_degen (o_out.degenerate),
    .i_final (o_out.final_corner)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the billboard quad corner block.
// ----------------------------------------------------------------------------
// Drives particle centres through the input channel, computes the expected
// four corners per particle in a bit-exact predictor, and compares every
// result transaction. Camera and quad size are rewritten between phases,
// including the range extremes and the degenerate (camera on axis) case.
// ----------------------------------------------------------------------------
module tb;
    import bqc_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_centre;

    typedef struct packed {
        logic [1:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               degen;
        logic               last;
    } t_corner_res;

    logic i_clk;
    logic i_rst_n;

    bqc_in_if  in_ch ();
    bqc_out_if out_ch ();
    bqc_cfg_if cfg_ch ();

    billboard_quad_corners u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (out_ch.source)
    );

    // Predictor copy of the registers
    logic signed [31:0] cam_x, cam_y, cam_z;
    logic [30:0]        quad_w, quad_h;

    t_centre     pending_centres[$];
    t_corner_res expected_corners[$];
    int          n_errors;
    int          n_corners;
    int          n_degen;
    bit          no_idle;
    int          hold_off;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Bitwise integer square root over 32 steps
    function automatic logic [63:0] root64(input logic [63:0] s);
        logic [63:0] rem, root, bitv;
        rem = s;
        root = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Expected four corners of one particle
    task automatic predict_corners(input t_centre c);
        logic signed [63:0] dx, dz, rx, rz, hy, sr, su;
        logic [63:0]        ax, az, len, ox, oz;
        logic               degen;
        t_corner_res        r;
        dx = 64'(c.x) - 64'(cam_x);
        dz = 64'(c.z) - 64'(cam_z);
        ax = dx < 0 ? -dx : dx;
        az = dz < 0 ? -dz : dz;
        rx = 0;
        rz = 0;
        hy = (64'(quad_h) + 1) >>> 1;
        degen = (ax | az) == 0;
        if (!degen) begin
            if ((ax | az) >= (64'd1 << 31)) begin
                ax = ax >> 1;
                az = az >> 1;
            end else begin
                while ((ax | az) < (64'd1 << 30)) begin
                    ax = ax << 1;
                    az = az << 1;
                end
            end
            len = root64(ax * ax + az * az);
            ox = (64'(quad_w) * az + len) / (2 * len);
            oz = (64'(quad_w) * ax + len) / (2 * len);
            if (dz > 0) rx = ox;
            else if (dz < 0) rx = -$signed(ox);
            if (dx > 0) rz = -$signed(oz);
            else if (dx < 0) rz = oz;
        end
        for (int k = 0; k < 4; k++) begin
            sr = k[0] ? -1 : 1;
            su = k[1] ? -1 : 1;
            r.idx   = 2'(k);
            r.x     = clamp32(64'(c.x) + sr * rx);
            r.y     = clamp32(64'(c.y) + su * hy);
            r.z     = clamp32(64'(c.z) + sr * rz);
            r.degen = degen;
            r.last  = (k == 3);
            expected_corners.push_back(r);
        end
    endtask

    // Driver: one centre per transaction, random idle bursts
    int idle_cnt;
    bit in_acc;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            idle_cnt    <= 0;
        end else if (in_ch.valid && !in_acc) begin
            // hold the offered item until it is taken
        end else if (idle_cnt > 0) begin
            in_ch.valid <= 1'b0;
            idle_cnt    <= idle_cnt - 1;
        end else if (pending_centres.size() > 0
                     && (no_idle || $urandom_range(0, 5) != 0)) begin
            in_ch.valid    <= 1'b1;
            in_ch.centre_x <= pending_centres[0].x;
            in_ch.centre_y <= pending_centres[0].y;
            in_ch.centre_z <= pending_centres[0].z;
        end else begin
            in_ch.valid <= 1'b0;
            if (!no_idle) idle_cnt <= $urandom_range(0, 2);
        end
    end

    // Input acceptance feeds the predictor
    always @(posedge i_clk) begin
        t_centre c;
        in_acc <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            c = pending_centres.pop_front();
            predict_corners(c);
        end
    end

    // Receiver backpressure
    int stall_cnt;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_cnt    <= 0;
        end else if (hold_off > 0) begin
            out_ch.ready <= 1'b0;
        end else if (stall_cnt > 0) begin
            out_ch.ready <= 1'b0;
            stall_cnt    <= stall_cnt - 1;
        end else if (!no_idle && $urandom_range(0, 6) == 0) begin
            out_ch.ready <= 1'b0;
            stall_cnt    <= $urandom_range(0, 2);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Long hold-off counter
    always @(negedge i_clk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // Monitor
    always @(posedge i_clk) begin
        t_corner_res e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_corners.size() == 0) begin
                $error("unexpected corner transaction");
                n_errors++;
            end else begin
                e = expected_corners.pop_front();
                n_corners++;
                if (e.degen) n_degen++;
                if (out_ch.corner_index !== e.idx) begin
                    $error("corner_index exp %0d got %0d", e.idx, out_ch.corner_index);
                    n_errors++;
                end
                if (out_ch.corner_x !== e.x) begin
                    $error("corner_x exp %0d got %0d", e.x, out_ch.corner_x);
                    n_errors++;
                end
                if (out_ch.corner_y !== e.y) begin
                    $error("corner_y exp %0d got %0d", e.y, out_ch.corner_y);
                    n_errors++;
                end
                if (out_ch.corner_z !== e.z) begin
                    $error("corner_z exp %0d got %0d", e.z, out_ch.corner_z);
                    n_errors++;
                end
                if (out_ch.degenerate !== e.degen) begin
                    $error("degenerate exp %0d got %0d", e.degen, out_ch.degenerate);
                    n_errors++;
                end
                if (out_ch.final_corner !== e.last) begin
                    $error("final_corner exp %0d got %0d", e.last, out_ch.final_corner);
                    n_errors++;
                end
            end
        end
    end

    // Register write through the config channel, predictor updated on accept
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_CAMERA_X:    cam_x = val;
            REG_CAMERA_Y:    cam_y = val;
            REG_CAMERA_Z:    cam_z = val;
            REG_QUAD_WIDTH:  quad_w = val[30:0];
            REG_QUAD_HEIGHT: quad_h = val[30:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_centres.size() > 0 || expected_corners.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return 32'($signed($urandom_range(0, 400)) - 200);
            default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    task automatic add_centre(input logic [31:0] x, y, z);
        t_centre c;
        c.x = x;
        c.y = y;
        c.z = z;
        pending_centres.push_back(c);
    endtask

    initial begin
        logic [31:0] edges[6] = '{32'h80000000, 32'h7fffffff, 0, 1, 32'hffffffff,
                                  32'h00010000};
        n_errors = 0;
        n_corners = 0;
        n_degen = 0;
        no_idle = 0;
        hold_off = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.centre_x = 0;
        in_ch.centre_y = 0;
        in_ch.centre_z = 0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_CAMERA_X;
        cfg_ch.data = 0;
        cam_x = 0;
        cam_y = 0;
        cam_z = 0;
        quad_w = 31'd65536;
        quad_h = 31'd65536;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset config, degenerate, extremes, saturation
        add_centre(0, 0, 0);
        add_centre(0, 32'h00050000, 0);
        add_centre(32'h00010000, 0, 0);
        add_centre(32'hffff0000, 0, 0);
        add_centre(0, 0, 32'h00010000);
        add_centre(0, 0, 32'hffff0000);
        add_centre(32'h00030000, 0, 32'h00040000);
        for (int i = 0; i < 6; i++)
            add_centre(edges[i], edges[5 - i], edges[(i + 2) % 6]);
        drain();

        // Extreme configuration: far camera, maximal size -> saturation
        write_reg(REG_CAMERA_X, 32'h80000000);
        write_reg(REG_CAMERA_Y, 32'h7fffffff);
        write_reg(REG_CAMERA_Z, 32'h7fffffff);
        write_reg(REG_QUAD_WIDTH, 32'hffffffff);
        write_reg(REG_QUAD_HEIGHT, 32'h7fffffff);
        add_centre(32'h7fffffff, 32'h7fffffff, 32'h80000000);
        add_centre(32'h80000000, 32'h80000000, 32'h7fffffff);
        add_centre(32'h80000000, 0, 32'h7fffffff);
        add_centre(32'h12345678, 32'hfedcba98, 32'h00000001);
        add_centre(32'h7fffffff, 0, 32'h7fffffff);
        drain();

        // Zero size
        write_reg(REG_QUAD_WIDTH, 0);
        write_reg(REG_QUAD_HEIGHT, 0);
        add_centre(32'h00020000, 32'h00010000, 32'hffff8000);
        add_centre(32'h80000000, 32'h00010000, 32'h7fffffff);
        drain();

        // Random phases with new settings each time
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_CAMERA_X, rnd_coord());
            write_reg(REG_CAMERA_Y, rnd_coord());
            write_reg(REG_CAMERA_Z, rnd_coord());
            write_reg(REG_QUAD_WIDTH, ph == 0 ? 32'h7fffffff : $urandom_range(0, 32'h00100000));
            write_reg(REG_QUAD_HEIGHT, ph == 1 ? 32'h7fffffff : $urandom);
            if (ph == 5) no_idle = 1;
            for (int i = 0; i < 48; i++) begin
                // occasionally a particle straight above or below the camera
                if ($urandom_range(0, 15) == 0)
                    add_centre(cam_x, rnd_coord(), cam_z);
                else
                    add_centre(rnd_coord(), rnd_coord(), rnd_coord());
            end
            // long output hold-off so the pipeline fills and stalls its input
            if (ph == 2) hold_off = 200;
            drain();
        end

        $display("Checked %0d corner transactions (%0d degenerate) over 9 configurations.",
                 n_corners, n_degen);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bqc_pkg.sv
hw/rtl/bqc_if.sv
hw/rtl/bqc_front.sv
hw/rtl/bqc_sqrt.sv
hw/rtl/bqc_offset.sv
hw/rtl/bqc_corner.sv
hw/rtl/billboard_quad_corners.sv
hw/rtl/bqc_checker.sv
tb/tb.sv
